>>> rtl/fsl_pkg.sv
`timescale 1ns / 1ps
// fsl_pkg: shared constants, codes, flag struct and arctangent table
// for the fibonacci sphere lattice point block; no dependencies
package fsl_pkg;

  localparam int DEF_INDEX_BITS = 20;
  localparam int DIV_STEPS      = 30;
  localparam int CORDIC_STEPS   = 30;
  localparam int SQRT_STEPS     = 31;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 32;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_VARIANT  = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COUNT    = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RADIUS   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_X = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_Y = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_Z = 3'd5;

  // lattice variants
  localparam logic [2:0] VAR_NAIVE  = 3'd0;
  localparam logic [2:0] VAR_FIRST  = 3'd1;
  localparam logic [2:0] VAR_SECOND = 3'd2;
  localparam logic [2:0] VAR_THIRD  = 3'd3;
  localparam logic [2:0] VAR_OFFSET = 3'd4;

  localparam logic [2:0]  VARIANT_RST = VAR_THIRD;
  localparam logic [30:0] RADIUS_RST  = 31'd65536;

  // lattice offsets, 16 fractional bits
  localparam logic [17:0] OFS_HALF      = 18'd32768;
  localparam logic [17:0] OFS_ONE_HALF  = 18'd98304;
  localparam logic [17:0] OFS_3_HALF    = 18'd229376;
  localparam logic [17:0] OFS_EPS       = 18'd23593;
  localparam logic signed [19:0] OFS_EPS_B = -20'sd18350;

  localparam logic signed [31:0] Q30_ONE     = 32'sh4000_0000;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] GOLDEN_LO = 32'h7F4A_7C15;
  localparam logic [31:0] GOLDEN_HI = 32'h9E37_79B9;

  typedef struct packed {
    logic err;
    logic north;
    logic south;
  } pt_flags_t;

  // arctangent of 2^-k in turns, 32 bits per turn
  function automatic logic [29:0] atan_turn(input logic [4:0] k);
    logic [29:0] v;
    unique case (k)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/fsl_if.sv
`timescale 1ns / 1ps
// fsl_if: valid/ready channel interfaces for sample indexes and points
// uses no package
interface fsl_in_if #(parameter int INDEX_BITS = 20);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] sample_index;
  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface fsl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               index_error;
  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output index_error, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input index_error, output ready);
endinterface

>>> rtl/fibonacci_sphere_lattice_point.sv
`timescale 1ns / 1ps
// fibonacci_sphere_lattice_point: one Fibonacci lattice point per index.
// Accepts one item per cycle unless a finished item waits at the output.
// Cost: input register, angle product, 30 divide/CORDIC cells, square,
// 31 square root cells, three scaling stages and the output register.
// Synchronous active-low reset loads register defaults, clears all valid bits.
module fibonacci_sphere_lattice_point #(
  parameter int INDEX_BITS = fsl_pkg::DEF_INDEX_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  fsl_in_if.sink                             in_ch,
  fsl_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [fsl_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [fsl_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int DW = INDEX_BITS + 17;
  localparam int ND = fsl_pkg::DIV_STEPS;
  localparam int NS = fsl_pkg::SQRT_STEPS;
  localparam logic [60:0] SQ_ONE = 61'(1) << 60;
  localparam logic signed [63:0] HALF_LSB = 64'sd536870912;

  // configuration registers
  logic [2:0]            variant_r;
  logic [INDEX_BITS-1:0] count_r;
  logic [30:0]           radius_r;
  logic signed [31:0]    cx_r, cy_r, cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= fsl_pkg::VARIANT_RST;
      count_r   <= '0;
      radius_r  <= fsl_pkg::RADIUS_RST;
      cx_r      <= '0;
      cy_r      <= '0;
      cz_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fsl_pkg::REG_VARIANT:  variant_r <= cfg_wdata[2:0];
        fsl_pkg::REG_COUNT:    count_r   <= cfg_wdata[INDEX_BITS-1:0];
        fsl_pkg::REG_RADIUS:   radius_r  <= cfg_wdata[30:0];
        fsl_pkg::REG_CENTER_X: cx_r      <= cfg_wdata;
        fsl_pkg::REG_CENTER_Y: cy_r      <= cfg_wdata;
        fsl_pkg::REG_CENTER_Z: cz_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance: stall only when a finished item waits at the output
  logic en;
  logic out_vld_r;
  logic m3_vld_r;
  assign en = out_ch.ready || !out_vld_r || !m3_vld_r;
  assign in_ch.ready = en;

  // stage 0: offsets, pole and range flags
  logic [INDEX_BITS-1:0] idx;
  logic                  poles;
  logic [17:0]           ofs_a;
  logic signed [19:0]    ofs_b;
  fsl_pkg::pt_flags_t    flg_c;

  always_comb begin
    idx   = in_ch.sample_index;
    poles = variant_r == fsl_pkg::VAR_THIRD || variant_r == fsl_pkg::VAR_OFFSET;
    unique case (variant_r)
      fsl_pkg::VAR_FIRST: begin
        ofs_a = fsl_pkg::OFS_HALF;
        ofs_b = '0;
      end
      fsl_pkg::VAR_SECOND: begin
        ofs_a = fsl_pkg::OFS_ONE_HALF;
        ofs_b = $signed({1'b0, fsl_pkg::OFS_ONE_HALF, 1'b0});
      end
      fsl_pkg::VAR_THIRD: begin
        ofs_a = fsl_pkg::OFS_3_HALF;
        ofs_b = $signed({1'b0, fsl_pkg::OFS_3_HALF, 1'b0});
      end
      fsl_pkg::VAR_OFFSET: begin
        ofs_a = fsl_pkg::OFS_EPS;
        ofs_b = fsl_pkg::OFS_EPS_B;
      end
      default: begin
        ofs_a = '0;
        ofs_b = '0;
      end
    endcase
    flg_c.err   = idx >= count_r;
    flg_c.north = idx == '0 && (count_r <= INDEX_BITS'(2) || poles);
    flg_c.south = !flg_c.north && idx == count_r - INDEX_BITS'(1) &&
                  (count_r == INDEX_BITS'(2) || poles);
  end

  logic                  s0_vld_r;
  fsl_pkg::pt_flags_t    s0_flg_r;
  logic [INDEX_BITS-1:0] s0_idx_r;
  logic [DW-1:0]         s0_num_r, s0_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_flg_r <= flg_c;
      s0_idx_r <= idx;
      s0_num_r <= DW'({idx, 16'h0}) + DW'(ofs_a);
      s0_den_r <= DW'({count_r, 16'h0}) + DW'(ofs_b);
    end
  end

  // stage 1: golden ratio angle as two partial products
  logic [63:0] plo_c, phi_c;
  assign plo_c = 64'(s0_idx_r) * 64'(fsl_pkg::GOLDEN_LO);
  assign phi_c = 64'(s0_idx_r) * 64'(fsl_pkg::GOLDEN_HI);

  logic               s1_vld_r;
  fsl_pkg::pt_flags_t s1_flg_r;
  logic [DW-1:0]      s1_num_r, s1_den_r;
  logic [31:0]        s1_plo_r, s1_phi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_flg_r <= s0_flg_r;
      s1_num_r <= s0_num_r;
      s1_den_r <= s0_den_r;
      s1_plo_r <= plo_c[63:32];
      s1_phi_r <= phi_c[31:0];
    end
  end

  // angle fold into a quarter turn either side of zero
  logic [31:0]        turn;
  logic signed [33:0] ang, ang_f;
  logic               flip;

  always_comb begin
    turn = s1_plo_r + s1_phi_r;
    ang  = 34'($signed(turn));
    priority if (ang > 34'(fsl_pkg::Q30_ONE)) begin
      ang_f = ang - 34'sh0_8000_0000;
      flip  = 1'b1;
    end else if (ang < -34'(fsl_pkg::Q30_ONE)) begin
      ang_f = ang + 34'sh0_8000_0000;
      flip  = 1'b1;
    end else begin
      ang_f = ang;
      flip  = 1'b0;
    end
  end

  // divide and CORDIC cells side by side
  logic               dv_vld [0:ND];
  fsl_pkg::pt_flags_t dv_flg [0:ND];
  logic [DW-1:0]      dv_rem [0:ND];
  logic [DW-1:0]      dv_den [0:ND];
  logic [ND-1:0]      dv_q   [0:ND];
  logic signed [33:0] cr_x   [0:ND];
  logic signed [33:0] cr_y   [0:ND];
  logic signed [33:0] cr_a   [0:ND];
  logic               cr_f   [0:ND];

  assign dv_vld[0] = s1_vld_r;
  assign dv_flg[0] = s1_flg_r;
  assign dv_rem[0] = s1_num_r;
  assign dv_den[0] = s1_den_r;
  assign dv_q[0]   = '0;
  assign cr_x[0]   = fsl_pkg::CORDIC_GAIN;
  assign cr_y[0]   = '0;
  assign cr_a[0]   = ang_f;
  assign cr_f[0]   = flip;

  for (genvar k = 0; k < ND; k++) begin : g_div
    fsl_div_cell #(.DW(DW)) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (dv_vld[k]),
      .flg_i (dv_flg[k]),
      .rem_i (dv_rem[k]),
      .den_i (dv_den[k]),
      .q_i   (dv_q[k]),
      .vld_o (dv_vld[k+1]),
      .flg_o (dv_flg[k+1]),
      .rem_o (dv_rem[k+1]),
      .den_o (dv_den[k+1]),
      .q_o   (dv_q[k+1])
    );
    fsl_cordic_cell #(.STEP(k)) u_cordic (
      .clk (clk),
      .en  (en),
      .x_i (cr_x[k]),
      .y_i (cr_y[k]),
      .a_i (cr_a[k]),
      .f_i (cr_f[k]),
      .x_o (cr_x[k+1]),
      .y_o (cr_y[k+1]),
      .a_o (cr_a[k+1]),
      .f_o (cr_f[k+1])
    );
  end

  // height and its square
  logic signed [31:0] z_c;
  logic [30:0]        zmag_c;

  always_comb begin
    z_c    = fsl_pkg::Q30_ONE - $signed({1'b0, dv_q[ND], 1'b0});
    zmag_c = z_c[31] ? 31'(-z_c) : 31'(z_c);
  end

  logic               zs_vld_r;
  fsl_pkg::pt_flags_t zs_flg_r;
  logic signed [31:0] zs_z_r;
  logic [60:0]        zs_sq_r;
  logic signed [33:0] zs_x_r, zs_y_r;
  logic               zs_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zs_vld_r <= 1'b0;
    end else if (en) begin
      zs_vld_r <= dv_vld[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zs_flg_r <= dv_flg[ND];
      zs_z_r   <= z_c;
      zs_sq_r  <= 61'(zmag_c) * 61'(zmag_c);
      zs_x_r   <= cr_x[ND];
      zs_y_r   <= cr_y[ND];
      zs_f_r   <= cr_f[ND];
    end
  end

  // square root cells with the point data riding alongside
  logic               sq_vld [0:NS];
  fsl_pkg::pt_flags_t sq_flg [0:NS];
  logic [60:0]        sq_v   [0:NS];
  logic [60:0]        sq_res [0:NS];
  logic signed [31:0] sb_z_r [0:NS];
  logic signed [33:0] sb_x_r [0:NS];
  logic signed [33:0] sb_y_r [0:NS];
  logic               sb_f_r [0:NS];

  assign sq_vld[0] = zs_vld_r;
  assign sq_flg[0] = zs_flg_r;
  assign sq_v[0]   = SQ_ONE - zs_sq_r;
  assign sq_res[0] = '0;
  assign sb_z_r[0] = zs_z_r;
  assign sb_x_r[0] = zs_x_r;
  assign sb_y_r[0] = zs_y_r;
  assign sb_f_r[0] = zs_f_r;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    fsl_sqrt_cell #(.STEP(k)) u_sqrt (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (sq_vld[k]),
      .flg_i (sq_flg[k]),
      .v_i   (sq_v[k]),
      .res_i (sq_res[k]),
      .vld_o (sq_vld[k+1]),
      .flg_o (sq_flg[k+1]),
      .v_o   (sq_v[k+1]),
      .res_o (sq_res[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sb_z_r[k+1] <= sb_z_r[k];
        sb_x_r[k+1] <= sb_x_r[k];
        sb_y_r[k+1] <= sb_y_r[k];
        sb_f_r[k+1] <= sb_f_r[k];
      end
    end
  end

  // M1: cosine and sine times ring radius
  logic signed [33:0] cs_c, sn_c;
  logic signed [31:0] rr_c;

  always_comb begin
    cs_c = sb_f_r[NS] ? -sb_x_r[NS] : sb_x_r[NS];
    sn_c = sb_f_r[NS] ? -sb_y_r[NS] : sb_y_r[NS];
    rr_c = $signed({1'b0, sq_res[NS][30:0]});
  end

  logic               m1_vld_r;
  fsl_pkg::pt_flags_t m1_flg_r;
  logic signed [63:0] m1_px_r, m1_py_r;
  logic signed [31:0] m1_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= sq_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_flg_r <= sq_flg[NS];
      m1_px_r  <= 64'(cs_c * 66'(rr_c));
      m1_py_r  <= 64'(sn_c * 66'(rr_c));
      m1_z_r   <= sb_z_r[NS];
    end
  end

  // M2: round to unit vector, poles override
  logic signed [63:0] ux_w, uy_w;
  assign ux_w = (m1_px_r + HALF_LSB) >>> 30;
  assign uy_w = (m1_py_r + HALF_LSB) >>> 30;

  logic               m2_vld_r;
  fsl_pkg::pt_flags_t m2_flg_r;
  logic signed [33:0] m2_ux_r, m2_uy_r, m2_uz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_flg_r <= m1_flg_r;
      priority if (m1_flg_r.north) begin
        m2_ux_r <= '0;
        m2_uy_r <= '0;
        m2_uz_r <= 34'(fsl_pkg::Q30_ONE);
      end else if (m1_flg_r.south) begin
        m2_ux_r <= '0;
        m2_uy_r <= '0;
        m2_uz_r <= -34'(fsl_pkg::Q30_ONE);
      end else begin
        m2_ux_r <= ux_w[33:0];
        m2_uy_r <= uy_w[33:0];
        m2_uz_r <= 34'(m1_z_r);
      end
    end
  end

  // M3: scale by sphere radius
  logic signed [31:0] rad_c;
  assign rad_c = $signed({1'b0, radius_r});

  logic               m3_err_r;
  logic signed [63:0] m3_px_r, m3_py_r, m3_pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_err_r <= m2_flg_r.err;
      m3_px_r  <= 64'(m2_ux_r * 66'(rad_c));
      m3_py_r  <= 64'(m2_uy_r * 66'(rad_c));
      m3_pz_r  <= 64'(m2_uz_r * 66'(rad_c));
    end
  end

  // round, add center, saturate
  function automatic logic signed [31:0] place(input logic signed [31:0] c,
                                               input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [34:0] s;
    t = (p + HALF_LSB) >>> 30;
    s = 35'(c) + 35'($signed(t[33:0]));
    priority if (s > 35'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return s[31:0];
    end
  endfunction

  logic               out_free;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic               out_err_r;
  assign out_free = out_ch.ready || !out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && m3_vld_r) begin
      out_err_r <= m3_err_r;
      out_x_r   <= m3_err_r ? '0 : place(cx_r, m3_px_r);
      out_y_r   <= m3_err_r ? '0 : place(cy_r, m3_py_r);
      out_z_r   <= m3_err_r ? '0 : place(cz_r, m3_pz_r);
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.pos_x       = out_x_r;
  assign out_ch.pos_y       = out_y_r;
  assign out_ch.pos_z       = out_z_r;
  assign out_ch.index_error = out_err_r;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_err_r |-> out_x_r == 0 && out_y_r == 0 && out_z_r == 0)
    else $error("out of range item with nonzero coordinates");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s0_vld_r)
    else $error("accepted item missing from first stage");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> out_vld_r && !out_ch.ready && m3_vld_r)
    else $error("pipeline stalled without a waiting result");
`endif

endmodule

>>> rtl/fsl_div_cell.sv
`timescale 1ns / 1ps
// fsl_div_cell: one restoring division step, carries valid and flags
// depends on fsl_pkg
module fsl_div_cell #(
  parameter int DW = 37
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           vld_i,
  input  fsl_pkg::pt_flags_t             flg_i,
  input  logic [DW-1:0]                  rem_i,
  input  logic [DW-1:0]                  den_i,
  input  logic [fsl_pkg::DIV_STEPS-1:0]  q_i,
  output logic                           vld_o,
  output fsl_pkg::pt_flags_t             flg_o,
  output logic [DW-1:0]                  rem_o,
  output logic [DW-1:0]                  den_o,
  output logic [fsl_pkg::DIV_STEPS-1:0]  q_o
);

  logic [DW:0] rem2;
  logic [DW:0] diff;
  logic        take;

  // shift and trial subtract
  always_comb begin
    rem2 = {rem_i, 1'b0};
    diff = rem2 - {1'b0, den_i};
    take = rem2 >= {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flg_o <= flg_i;
      den_o <= den_i;
      rem_o <= take ? diff[DW-1:0] : rem2[DW-1:0];
      q_o   <= {q_i[fsl_pkg::DIV_STEPS-2:0], take};
    end
  end

endmodule

>>> rtl/fsl_cordic_cell.sv
`timescale 1ns / 1ps
// fsl_cordic_cell: one CORDIC rotation step with a fixed shift
// depends on fsl_pkg for the arctangent table
module fsl_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [33:0] x_i,
  input  logic signed [33:0] y_i,
  input  logic signed [33:0] a_i,
  input  logic               f_i,
  output logic signed [33:0] x_o,
  output logic signed [33:0] y_o,
  output logic signed [33:0] a_o,
  output logic               f_o
);

  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;

  // shifted cross terms and step angle
  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    at = $signed(34'(fsl_pkg::atan_turn(5'(STEP))));
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      f_o <= f_i;
      if (!a_i[33]) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        a_o <= a_i - at;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        a_o <= a_i + at;
      end
    end
  end

endmodule

>>> rtl/fsl_sqrt_cell.sv
`timescale 1ns / 1ps
// fsl_sqrt_cell: one digit of a bitwise integer square root
// depends on fsl_pkg for the flag struct
module fsl_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  fsl_pkg::pt_flags_t flg_i,
  input  logic [60:0]        v_i,
  input  logic [60:0]        res_i,
  output logic               vld_o,
  output fsl_pkg::pt_flags_t flg_o,
  output logic [60:0]        v_o,
  output logic [60:0]        res_o
);

  localparam logic [60:0] BIT = 61'(1) << (60 - 2 * STEP);

  logic [61:0] trial;
  logic        fit;

  always_comb begin
    trial = {1'b0, res_i} + {1'b0, BIT};
    fit   = {1'b0, v_i} >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flg_o <= flg_i;
      if (fit) begin
        v_o   <= v_i - trial[60:0];
        res_o <= (res_i >> 1) + BIT;
      end else begin
        v_o   <= v_i;
        res_o <= res_i >> 1;
      end
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for fibonacci_sphere_lattice_point; drives sample indexes,
// mirrors the registers and predicts each lattice point or takes it from the stimulus row; needs fsl_pkg and fsl_if
module tb;

  localparam int IDX_W     = 20;
  localparam int DRAIN_GAP = 80;
  localparam int STALL_MAX = 4000;
  localparam logic [63:0] GOLD_STEP = {fsl_pkg::GOLDEN_HI, fsl_pkg::GOLDEN_LO};

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               err;
  } point_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [31:0] wdata;
    logic [19:0] idx;
    bit          typed;
    point_t      pt;
  } stim_row_t;

  // arctangent of 2^-k, 32 bits per turn
  localparam longint ATAN_TBL [30] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [fsl_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
  logic [fsl_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

  fsl_in_if #(.INDEX_BITS(IDX_W)) in_ch ();
  fsl_out_if out_ch ();

  fibonacci_sphere_lattice_point #(.INDEX_BITS(IDX_W)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // register mirror
  logic [2:0]         m_variant;
  logic [19:0]        m_count;
  logic [30:0]        m_radius;
  logic signed [31:0] m_cx, m_cy, m_cz;

  point_t    pending_pts[$];
  stim_row_t rows[$];
  int  mismatches;
  int  stall_cycles;
  bit  idle_on;
  int  rdy_hold;

  // clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // center plus scaled unit component, saturated
  function automatic logic signed [31:0] place_coord(longint ctr, longint unit);
    longint v;
    v = ctr + ((unit * longint'(m_radius) + (longint'(1) << 29)) >>> 30);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // lattice point for one sample index under the current registers
  function automatic point_t lattice_point(logic [19:0] idx);
    point_t p;
    longint unsigned n, num, den, rem, r, v, res, bt;
    longint a, b, xq, z, ang, cx, cy, dx, dy, ux, uy, uz;
    logic [63:0] prod;
    logic [31:0] turn;
    bit poles, flip;
    n = 64'(m_count);
    poles = (m_variant == fsl_pkg::VAR_THIRD) || (m_variant == fsl_pkg::VAR_OFFSET);
    ux = 0; uy = 0; uz = 0;
    if (64'(idx) >= n) begin
      p.x = '0; p.y = '0; p.z = '0; p.err = 1'b1;
      return p;
    end
    if (idx == 0 && (n <= 2 || poles)) begin
      uz = longint'(fsl_pkg::Q30_ONE);
    end else if (64'(idx) == n - 1 && (n == 2 || poles)) begin
      uz = -longint'(fsl_pkg::Q30_ONE);
    end else begin
      unique case (m_variant)
        fsl_pkg::VAR_FIRST: begin
          a = longint'(fsl_pkg::OFS_HALF); b = 0;
        end
        fsl_pkg::VAR_SECOND: begin
          a = longint'(fsl_pkg::OFS_ONE_HALF); b = 2 * a;
        end
        fsl_pkg::VAR_THIRD: begin
          a = longint'(fsl_pkg::OFS_3_HALF); b = 2 * a;
        end
        fsl_pkg::VAR_OFFSET: begin
          a = longint'(fsl_pkg::OFS_EPS); b = longint'(fsl_pkg::OFS_EPS_B);
        end
        default: begin
          a = 0; b = 0;
        end
      endcase
      num = (longint'(idx) << 16) + a;
      den = longint'((longint'(n) << 16) + b);
      rem = num; xq = 0;
      // restoring division, 30 quotient bits
      for (int k = 0; k < 30; k++) begin
        rem = rem << 1;
        xq = xq << 1;
        if (rem >= den) begin rem = rem - den; xq = xq | 1; end
      end
      z = longint'(fsl_pkg::Q30_ONE) - 2 * xq;
      // integer square root of 1 - z^2
      v = (longint'(1) << 60) - longint'(z * z);
      res = 0; bt = longint'(1) << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
        if (v >= res + bt) begin v = v - (res + bt); res = (res >> 1) + bt; end
        else res = res >> 1;
        bt = bt >> 2;
      end
      r = res;
      // azimuth in turns, folded to a quarter turn, then rotated
      prod = {44'd0, idx} * GOLD_STEP;
      turn = prod[63:32];
      ang = longint'(signed'(turn));
      flip = 0;
      if (ang > longint'(fsl_pkg::Q30_ONE)) begin
        ang = ang - 64'sh8000_0000; flip = 1;
      end else if (ang < -longint'(fsl_pkg::Q30_ONE)) begin
        ang = ang + 64'sh8000_0000; flip = 1;
      end
      cx = longint'(fsl_pkg::CORDIC_GAIN); cy = 0;
      for (int k = 0; k < 30; k++) begin
        dx = cy >>> k; dy = cx >>> k;
        if (ang >= 0) begin cx = cx - dx; cy = cy + dy; ang = ang - ATAN_TBL[k]; end
        else begin cx = cx + dx; cy = cy - dy; ang = ang + ATAN_TBL[k]; end
      end
      if (flip) begin cx = -cx; cy = -cy; end
      ux = (cx * longint'(r) + (longint'(1) << 29)) >>> 30;
      uy = (cy * longint'(r) + (longint'(1) << 29)) >>> 30;
      uz = z;
    end
    p.x = place_coord(m_cx, ux);
    p.y = place_coord(m_cy, uy);
    p.z = place_coord(m_cz, uz);
    p.err = 1'b0;
    return p;
  endfunction

  function automatic void add_item(logic [19:0] idx, bit typed = 0,
                                   logic [31:0] ex = 0, logic [31:0] ey = 0,
                                   logic [31:0] ez = 0, logic ee = 0);
    stim_row_t s;
    s.is_cfg = 0; s.addr = '0; s.wdata = '0; s.idx = idx; s.typed = typed;
    s.pt = '{ex, ey, ez, ee};
    rows.insert(rows.size(), s);
  endfunction

  function automatic void add_cfg(logic [2:0] addr, logic [31:0] wdata);
    stim_row_t s;
    s.is_cfg = 1; s.addr = addr; s.wdata = wdata; s.idx = '0; s.typed = 0;
    s.pt = '0;
    rows.insert(rows.size(), s);
  endfunction

  // register write once every point in flight has come back
  task automatic write_reg(logic [2:0] addr, logic [31:0] wdata);
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= addr; cfg_wdata <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (addr)
      fsl_pkg::REG_VARIANT:  m_variant = wdata[2:0];
      fsl_pkg::REG_COUNT:    m_count = wdata[19:0];
      fsl_pkg::REG_RADIUS:   m_radius = wdata[30:0];
      fsl_pkg::REG_CENTER_X: m_cx = wdata;
      fsl_pkg::REG_CENTER_Y: m_cy = wdata;
      fsl_pkg::REG_CENTER_Z: m_cz = wdata;
      default: ;
    endcase
  endtask

  // send one index; valid stays high into the next item
  task automatic send_index(logic [19:0] idx, bit typed, point_t typed_pt);
    bit rdy;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_index <= idx;
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      if (rdy)
        pending_pts.insert(pending_pts.size(), typed ? typed_pt : lattice_point(idx));
      @(posedge clk);
    end while (!rdy);
  endtask

  // random index: mostly in range, with poles and out-of-range ones mixed in
  function automatic logic [19:0] pick_index();
    int c;
    c = $urandom_range(0, 9);
    if (m_count == 0 || c == 0) return 20'($urandom);
    if (c == 1) return 20'd0;
    if (c == 2) return m_count - 20'd1;
    if (c == 3) return 20'(m_count + $urandom_range(0, 3));
    return 20'($urandom_range(0, m_count - 1));
  endfunction

  task automatic random_setup();
    case ($urandom_range(0, 5))
      0: write_reg(fsl_pkg::REG_COUNT, $urandom_range(0, 2));
      1, 2: write_reg(fsl_pkg::REG_COUNT, $urandom_range(3, 64));
      3: write_reg(fsl_pkg::REG_COUNT, $urandom);
      4: write_reg(fsl_pkg::REG_COUNT, 32'h000F_FFFF);
      default: write_reg(fsl_pkg::REG_COUNT, $urandom_range(65, 5000));
    endcase
    write_reg(fsl_pkg::REG_VARIANT, {$urandom} & 32'hFFFF_FFF8 | $urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: write_reg(fsl_pkg::REG_RADIUS, 32'h0);
      1: write_reg(fsl_pkg::REG_RADIUS, 32'hFFFF_FFFF);
      2: write_reg(fsl_pkg::REG_RADIUS, $urandom_range(1, 32'h00FF_FFFF));
      default: write_reg(fsl_pkg::REG_RADIUS, $urandom);
    endcase
    for (int k = 0; k < 3; k++) begin
      logic [31:0] cv;
      case ($urandom_range(0, 3))
        0: cv = 32'h7FFF_FFFF;
        1: cv = 32'h8000_0000;
        2: cv = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        default: cv = $urandom;
      endcase
      write_reg(3'(fsl_pkg::REG_CENTER_X + k), cv);
    end
  endtask

  // result ready with random stall bursts
  always @(posedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (idle_on && rst_n && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      rdy_hold <= $urandom_range(1, 14);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    point_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.index_error};
      if (pending_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point x=%h y=%h z=%h err=%b",
                   got.x, got.y, got.z, got.err);
      end else begin
        want = pending_pts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: exp x=%h y=%h z=%h err=%b got x=%h y=%h z=%h err=%b",
                     want.x, want.y, want.z, want.err,
                     got.x, got.y, got.z, got.err);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(negedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.sample_index = '0;
    out_ch.ready = 1'b1;
    rdy_hold = 0; idle_on = 1; mismatches = 0; stall_cycles = 0;
    m_variant = fsl_pkg::VARIANT_RST; m_count = '0; m_radius = fsl_pkg::RADIUS_RST;
    m_cx = '0; m_cy = '0; m_cz = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty count, tiny counts, full count, every variant, saturation
    add_item(20'd0, 1, 0, 0, 0, 1);
    add_item(20'hFFFFF, 1, 0, 0, 0, 1);
    add_cfg(fsl_pkg::REG_COUNT, 32'd1);
    add_item(20'd0, 1, 0, 0, 32'd65536, 0);
    add_item(20'd1, 1, 0, 0, 0, 1);
    add_cfg(fsl_pkg::REG_VARIANT, 32'(fsl_pkg::VAR_NAIVE));
    add_cfg(fsl_pkg::REG_COUNT, 32'd2);
    add_item(20'd0, 1, 0, 0, 32'd65536, 0);
    add_item(20'd1, 1, 0, 0, -32'sd65536, 0);
    add_cfg(fsl_pkg::REG_COUNT, 32'hFFFF_FFFF);
    add_item(20'd1);
    add_item(20'hFFFFE);
    add_item(20'hFFFFF, 1, 0, 0, 0, 1);
    add_cfg(fsl_pkg::REG_COUNT, 32'd10);
    add_item(20'd3);
    add_cfg(fsl_pkg::REG_VARIANT, 32'(fsl_pkg::VAR_FIRST));
    add_item(20'd3); add_item(20'd7);
    add_cfg(fsl_pkg::REG_VARIANT, 32'(fsl_pkg::VAR_SECOND));
    add_item(20'd3); add_item(20'd7);
    add_cfg(fsl_pkg::REG_VARIANT, 32'(fsl_pkg::VAR_THIRD));
    add_item(20'd0, 1, 0, 0, 32'd65536, 0);
    add_item(20'd9, 1, 0, 0, -32'sd65536, 0);
    add_item(20'd4);
    add_cfg(fsl_pkg::REG_VARIANT, 32'(fsl_pkg::VAR_OFFSET));
    add_item(20'd9, 1, 0, 0, -32'sd65536, 0);
    add_item(20'd5);
    add_cfg(fsl_pkg::REG_VARIANT, 32'd7);
    add_item(20'd5);
    add_cfg(fsl_pkg::REG_VARIANT, 32'(fsl_pkg::VAR_THIRD));
    add_cfg(fsl_pkg::REG_RADIUS, 32'hFFFF_FFFF);
    add_cfg(fsl_pkg::REG_CENTER_X, 32'h8000_0000);
    add_cfg(fsl_pkg::REG_CENTER_Y, 32'h7FFF_FFFF);
    add_cfg(fsl_pkg::REG_CENTER_Z, 32'h7FFF_FFFF);
    add_item(20'd0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    add_item(20'd9);
    add_item(20'd3);

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        in_ch.valid <= 1'b0;
        write_reg(rows[k].addr, rows[k].wdata);
      end else begin
        send_index(rows[k].idx, rows[k].typed, rows[k].pt);
      end
    end

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 13; ph++) begin
      in_ch.valid <= 1'b0;
      random_setup();
      if (ph == 12) idle_on = 0;
      repeat (ph == 12 ? 200 : 120) send_index(pick_index(), 0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
rtl/fsl_pkg.sv
rtl/fsl_if.sv
rtl/fsl_div_cell.sv
rtl/fsl_cordic_cell.sv
rtl/fsl_sqrt_cell.sv
rtl/fibonacci_sphere_lattice_point.sv
sim/tb.sv
